@@ rtl/core/skst_pkg.sv @@
// Shared types and constants for the sorted keyed strength table.
package skst_pkg;

   localparam int unsigned CapacityDefault = 64;
   localparam logic [15:0] ScaleReset = 16'hFFFF;

   typedef enum logic [1:0] {
      MODE_REGISTER = 2'd0,
      MODE_DELTA    = 2'd1,
      MODE_POLICY   = 2'd2,
      MODE_LOOKUP   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_ZERO_KEY = 3'd1,
      ST_FULL     = 3'd2,
      ST_DUP      = 3'd3,
      ST_MISSING  = 3'd4
   } status_type;

   // controller -> datapath commands
   typedef struct packed {
      logic latch;      // capture the request
      logic scan_rd;    // issue a read of the scan index
      logic scan_step;  // advance the scan index
      logic shift_rd;   // read the entry below the shift index
      logic shift_wr;   // write the shifted entry
      logic ins_wr;     // write the new entry at the found place
      logic upd_wr;     // write back the updated entry
      logic fin_rd;     // read the found entry for the result
      logic respond;    // drive the result
      status_type status;
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic       zero_key;
      logic       full;
      logic       scan_end;   // scan index reached the count
      logic       hit;        // registered entry equals key
      logic       past;       // registered entry exceeds key
      logic       shift_done; // shift index reached the insert place
      mode_type   mode;
   } stat_type;

endpackage

@@ rtl/core/skst_ctrl.sv @@
// Controller state machine of the sorted keyed strength table.
module skst_ctrl
   import skst_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_CMP, S_SHIFT_RD, S_SHIFT_WR,
      S_INSERT, S_UPDATE, S_FIN_RD, S_RESP_OK, S_RESP_ERR
   } state_type;

   state_type  state_ff;
   status_type err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         err_ff   <= ST_OK;
      end else begin
         case (state_ff)
            S_IDLE: if (start) state_ff <= S_CHECK;
            S_CHECK: begin
               if (stat.mode == MODE_REGISTER && stat.zero_key) begin
                  err_ff <= ST_ZERO_KEY; state_ff <= S_RESP_ERR;
               end else if (stat.mode == MODE_REGISTER && stat.full) begin
                  err_ff <= ST_FULL; state_ff <= S_RESP_ERR;
               end else begin
                  state_ff <= S_SCAN_RD;
               end
            end
            S_SCAN_RD: begin
               if (stat.scan_end) begin
                  if (stat.mode == MODE_REGISTER) state_ff <= S_SHIFT_RD;
                  else begin err_ff <= ST_MISSING; state_ff <= S_RESP_ERR; end
               end else begin
                  state_ff <= S_SCAN_CMP;
               end
            end
            S_SCAN_CMP: begin
               if (stat.hit) begin
                  if (stat.mode == MODE_REGISTER) begin
                     err_ff <= ST_DUP; state_ff <= S_RESP_ERR;
                  end else begin
                     state_ff <= S_UPDATE;
                  end
               end else if (stat.past) begin
                  if (stat.mode == MODE_REGISTER) state_ff <= S_SHIFT_RD;
                  else begin err_ff <= ST_MISSING; state_ff <= S_RESP_ERR; end
               end else begin
                  state_ff <= S_SCAN_RD;
               end
            end
            S_SHIFT_RD: state_ff <= stat.shift_done ? S_INSERT : S_SHIFT_WR;
            S_SHIFT_WR: state_ff <= S_SHIFT_RD;
            S_INSERT:   state_ff <= S_FIN_RD;
            S_UPDATE:   state_ff <= S_FIN_RD;
            S_FIN_RD:   state_ff <= S_RESP_OK;
            S_RESP_OK:  state_ff <= S_IDLE;
            S_RESP_ERR: state_ff <= S_IDLE;
            default:    state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd = '0;
      cmd.status    = (state_ff == S_RESP_ERR) ? err_ff : ST_OK;
      cmd.latch     = (state_ff == S_IDLE) && start;
      cmd.scan_rd   = (state_ff == S_SCAN_RD) && !stat.scan_end;
      cmd.scan_step = (state_ff == S_SCAN_CMP) && !stat.hit && !stat.past;
      cmd.shift_rd  = (state_ff == S_SHIFT_RD) && !stat.shift_done;
      cmd.shift_wr  = (state_ff == S_SHIFT_WR);
      cmd.ins_wr    = (state_ff == S_INSERT);
      cmd.upd_wr    = (state_ff == S_UPDATE);
      cmd.fin_rd    = (state_ff == S_FIN_RD);
      cmd.respond   = (state_ff == S_RESP_OK) || (state_ff == S_RESP_ERR);
   end

   assign busy = (state_ff != S_IDLE);

`ifndef SYNTHESIS
   a_resp_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> !busy)
      else $error("result not followed by idle");
   a_latch_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |=> state_ff == S_CHECK)
      else $error("accept did not enter check");
   a_ok_path: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP_OK |-> $past(state_ff) == S_FIN_RD)
      else $error("ok result without final read");
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP_ERR |-> err_ff != ST_OK)
      else $error("error result with ok code");
`endif

endmodule

@@ rtl/core/skst_dpath.sv @@
// Datapath of the sorted keyed strength table: entry memory, scan and shift.
module skst_dpath
   import skst_pkg::*;
#(
   parameter int unsigned CAPACITY = CapacityDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [1:0]  req_mode,
   input  logic [63:0] req_route_key,
   input  logic [63:0] req_owner_id,
   input  logic [31:0] req_strength_in,
   input  logic [31:0] req_policy_in,
   input  logic [31:0] req_delta,
   input  logic [15:0] scale,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_out_owner,
   output logic [15:0] rsp_out_strength,
   output logic [31:0] rsp_out_policy,
   output logic [6:0]  rsp_entry_total
);

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   typedef struct packed {
      logic [63:0] key;
      logic [63:0] owner;
      logic [15:0] strength;
      logic [31:0] policy;
   } entry_type;

   entry_type mem [CAPACITY];

   mode_type    mode_ff;
   logic [63:0] key_ff, owner_ff;
   logic [31:0] str_ff, pol_ff, delta_ff;
   logic [CW-1:0] count_ff, idx_ff, sidx_ff;
   entry_type   rd_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     wr_data;
   logic          rd_en;
   logic [15:0]   ins_str;
   logic signed [33:0] sum;
   logic [15:0]   upd_str;

   assign ins_str = (str_ff > {16'd0, scale}) ? scale : str_ff[15:0];
   assign sum = $signed({18'd0, rd_ff.strength}) + $signed({{2{delta_ff[31]}}, delta_ff});
   assign upd_str = sum[33] ? 16'd0 :
                    (sum > $signed({18'd0, scale})) ? scale : sum[15:0];

   always_comb begin
      wr_en   = cmd.shift_wr || cmd.ins_wr || cmd.upd_wr;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rd_ff;
      rd_en   = cmd.scan_rd || cmd.shift_rd || cmd.fin_rd;
      rd_addr = idx_ff[AW-1:0];
      if (cmd.shift_wr) begin
         wr_addr = sidx_ff[AW-1:0];
      end else if (cmd.ins_wr) begin
         wr_data = '{key: key_ff, owner: owner_ff, strength: ins_str, policy: pol_ff};
      end else if (cmd.upd_wr) begin
         if (mode_ff == MODE_DELTA) wr_data.strength = upd_str;
         if (mode_ff == MODE_POLICY) wr_data.policy = pol_ff;
      end
      if (cmd.shift_rd) rd_addr = AW'(sidx_ff - CW'(1));
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff  <= mode_type'(req_mode);
         key_ff   <= req_route_key;
         owner_ff <= req_owner_id;
         str_ff   <= req_strength_in;
         pol_ff   <= req_policy_in;
         delta_ff <= req_delta;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         idx_ff    <= '0;
         sidx_ff   <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.respond;
         if (cmd.latch) begin
            idx_ff  <= '0;
            sidx_ff <= count_ff;
         end
         if (cmd.scan_step) idx_ff <= idx_ff + CW'(1);
         // move one entry up, walking down toward the insert place
         if (cmd.shift_wr) sidx_ff <= sidx_ff - CW'(1);
         if (cmd.ins_wr) count_ff <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_status <= cmd.status;
         if (cmd.status == ST_OK) begin
            rsp_out_owner    <= rd_ff.owner;
            rsp_out_strength <= rd_ff.strength;
            rsp_out_policy   <= rd_ff.policy;
         end else begin
            rsp_out_owner    <= '0;
            rsp_out_strength <= '0;
            rsp_out_policy   <= '0;
         end
         rsp_entry_total <= 7'(count_ff);
      end
   end

   always_comb begin
      stat.zero_key   = (key_ff == 64'd0);
      stat.full       = (count_ff >= CW'(CAPACITY));
      stat.scan_end   = (idx_ff >= count_ff);
      stat.hit        = (rd_ff.key == key_ff);
      stat.past       = (rd_ff.key > key_ff);
      stat.shift_done = (sidx_ff == idx_ff);
      stat.mode       = mode_ff;
   end

`ifndef SYNTHESIS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_wr |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow count");
   a_shift_order: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_wr |-> sidx_ff > idx_ff)
      else $error("shift below insert place");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_out_owner == 64'd0)
      else $error("error result carries data");
`endif

endmodule

@@ rtl/core/sorted_keyed_strength_table.sv @@
// Top level of the sorted keyed strength table.
//  channel | ports                            | handshake
//  request | req_mode .. req_delta            | start high while busy low
//  result  | rsp_status .. rsp_entry_total    | rsp_valid, one cycle
//  config  | csr_wr_en, csr_wr_data           | write when enable high
// An item holds busy until its result is sent; the entry memory reads one entry
// at a time during the key scan and the entry shift for insert.
// The result shows in the same cycle that busy drops; the next item may start then.
// Reset clears the entry count and the scale to full; entry contents stay.
// The receiver cannot stall; each result shows for one cycle.
module sorted_keyed_strength_table
   import skst_pkg::*;
#(
   parameter int unsigned CAPACITY = CapacityDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [63:0] req_route_key,
   input  logic [63:0] req_owner_id,
   input  logic [31:0] req_strength_in,
   input  logic [31:0] req_policy_in,
   input  logic signed [31:0] req_delta,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_out_owner,
   output logic [15:0] rsp_out_strength,
   output logic [31:0] rsp_out_policy,
   output logic [6:0]  rsp_entry_total
);

   logic [15:0] scale_ff;
   cmd_type     cmd;
   stat_type    stat;

   always_ff @(posedge clock) begin
      if (reset) scale_ff <= ScaleReset;
      else if (csr_wr_en) scale_ff <= csr_wr_data;
   end

   skst_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .cmd(cmd)
   );

   skst_dpath #(.CAPACITY(CAPACITY)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_mode(req_mode), .req_route_key(req_route_key),
      .req_owner_id(req_owner_id), .req_strength_in(req_strength_in),
      .req_policy_in(req_policy_in), .req_delta(req_delta),
      .scale(scale_ff), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_out_owner(rsp_out_owner), .rsp_out_strength(rsp_out_strength),
      .rsp_out_policy(rsp_out_policy), .rsp_entry_total(rsp_entry_total)
   );

endmodule
